>>> rtl/tci_pkg.sv
// ----------------------------------------------------------------------------
// tci_pkg
// Shared widths, types and per-stage step functions of the circle solver.
// ----------------------------------------------------------------------------
package tci_pkg;

	localparam int FRAC_BITS = 16;
	localparam int CW = 32;
	localparam int DW = CW + 1;
	localparam int SW = 2 * DW;
	localparam int RW = SW / 2;
	localparam int SQ_N = RW;
	localparam int SR_W = RW + 2;
	localparam int NW = SW + 1;
	localparam int QW = RW;
	localparam int DVW = NW - QW;
	localparam int DV_N = QW;
	localparam int XW = QW + 3;
	localparam int TW = 17;

	localparam int TOL_ROUND = ((2 ** FRAC_BITS) + 50) / 100;
	localparam logic [TW-1:0] TOL_RESET = TW'((TOL_ROUND > 131071) ? 131071 : TOL_ROUND);

	localparam logic REG_TOL = 1'b0;

	localparam int DIST_LAT = 4 + SQ_N;
	localparam int SOLVE_LAT = 4 + DV_N + 2 + SQ_N;
	localparam int PLACE_LAT = 2 + DV_N + 5;

	typedef logic signed [CW-1:0] crd_t;
	typedef logic signed [DW-1:0] dif_t;

	typedef enum logic [1:0] {
		ST_TWO,
		ST_TAN,
		ST_FAR,
		ST_SHARE
	} status_t;

	typedef struct packed {
		crd_t ax;
		crd_t ay;
		crd_t bx;
		crd_t by;
		crd_t px;
		crd_t py;
	} pos_t;

	typedef struct packed {
		crd_t ax;
		crd_t ay;
		dif_t ex;
		dif_t ey;
	} geo_t;

	typedef struct packed {
		geo_t g;
		logic [RW-1:0] r1;
		logic [RW-1:0] r2;
		logic [RW-1:0] d;
	} dist_t;

	typedef struct packed {
		geo_t g;
		logic [RW-1:0] r1;
		logic [RW-1:0] d;
		logic [RW-1:0] aq;
		logic [RW-1:0] h;
		logic neg;
		logic tan;
		logic far;
	} sol_t;

	typedef struct packed {
		crd_t fx;
		crd_t fy;
		crd_t sx;
		crd_t sy;
		status_t st;
	} res_t;

	typedef struct packed {
		logic [SR_W-1:0] rem;
		logic [RW-1:0] root;
	} sq_st_t;

	typedef struct packed {
		logic [DVW-1:0] rem;
		logic [QW-1:0] quo;
		logic [QW-1:0] low;
	} dv_st_t;

	function automatic logic [DW-1:0] mag(dif_t v);
		return v[DW-1] ? DW'(-v) : DW'(v);
	endfunction

	// One root bit per call: bring down two radicand bits and try a one.
	function automatic sq_st_t sq_step(sq_st_t st, logic [1:0] pair);
		logic [SR_W+1:0] tr;
		logic [SR_W+1:0] tv;
		sq_st_t r;
		tr = {st.rem, pair};
		tv = (SR_W + 2)'({st.root, 2'b01});
		if (tr >= tv) begin
			r.rem = SR_W'(tr - tv);
			r.root = {st.root[RW-2:0], 1'b1};
		end else begin
			r.rem = SR_W'(tr);
			r.root = {st.root[RW-2:0], 1'b0};
		end
		return r;
	endfunction

	// One quotient bit per call of a restoring division.
	function automatic dv_st_t dv_step(dv_st_t st, logic [DVW-1:0] dv);
		logic [DVW:0] tr;
		dv_st_t r;
		tr = {st.rem, st.low[QW-1]};
		r.low = {st.low[QW-2:0], 1'b0};
		if (tr >= {1'b0, dv}) begin
			r.rem = DVW'(tr - {1'b0, dv});
			r.quo = {st.quo[QW-2:0], 1'b1};
		end else begin
			r.rem = DVW'(tr);
			r.quo = {st.quo[QW-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage

>>> rtl/tci_dist.sv
// ----------------------------------------------------------------------------
// tci_dist
// Differences, squares and three pipelined square roots giving r1, r2 and D.
// ----------------------------------------------------------------------------
module tci_dist (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  tci_pkg::pos_t   pos,
	output logic            out_valid,
	output tci_pkg::dist_t  rng
);

	logic [tci_pkg::DIST_LAT-1:0] vld_q;

	tci_pkg::dif_t dif_s1 [6];
	tci_pkg::crd_t ax_s1, ay_s1;
	logic [tci_pkg::DW-1:0] m_s2 [6];
	tci_pkg::geo_t g_s2, g_s3, g_s4;
	logic [tci_pkg::SW-1:0] sq_s3 [6];
	logic [tci_pkg::SW-1:0] rad_s4 [3];

	tci_pkg::sq_st_t sqst_s [3][tci_pkg::SQ_N];
	logic [tci_pkg::SW-1:0] sqrad_s [3][tci_pkg::SQ_N];
	tci_pkg::geo_t sqg_s [tci_pkg::SQ_N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[tci_pkg::DIST_LAT-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dif_s1[0] <= tci_pkg::DW'(pos.px) - tci_pkg::DW'(pos.ax);
			dif_s1[1] <= tci_pkg::DW'(pos.py) - tci_pkg::DW'(pos.ay);
			dif_s1[2] <= tci_pkg::DW'(pos.px) - tci_pkg::DW'(pos.bx);
			dif_s1[3] <= tci_pkg::DW'(pos.py) - tci_pkg::DW'(pos.by);
			dif_s1[4] <= tci_pkg::DW'(pos.bx) - tci_pkg::DW'(pos.ax);
			dif_s1[5] <= tci_pkg::DW'(pos.by) - tci_pkg::DW'(pos.ay);
			ax_s1 <= pos.ax;
			ay_s1 <= pos.ay;

			for (int i = 0; i < 6; i++) begin
				m_s2[i] <= tci_pkg::mag(dif_s1[i]);
			end
			g_s2.ax <= ax_s1;
			g_s2.ay <= ay_s1;
			g_s2.ex <= dif_s1[4];
			g_s2.ey <= dif_s1[5];

			for (int i = 0; i < 6; i++) begin
				sq_s3[i] <= m_s2[i] * m_s2[i];
			end
			g_s3 <= g_s2;

			for (int j = 0; j < 3; j++) begin
				rad_s4[j] <= sq_s3[2*j] + sq_s3[2*j+1];
			end
			g_s4 <= g_s3;

			for (int j = 0; j < 3; j++) begin
				sqst_s[j][0] <= tci_pkg::sq_step('0, rad_s4[j][tci_pkg::SW-1 -: 2]);
				sqrad_s[j][0] <= {rad_s4[j][tci_pkg::SW-3:0], 2'b00};
				for (int k = 1; k < tci_pkg::SQ_N; k++) begin
					sqst_s[j][k] <= tci_pkg::sq_step(sqst_s[j][k-1],
						sqrad_s[j][k-1][tci_pkg::SW-1 -: 2]);
					sqrad_s[j][k] <= {sqrad_s[j][k-1][tci_pkg::SW-3:0], 2'b00};
				end
			end
			sqg_s[0] <= g_s4;
			for (int k = 1; k < tci_pkg::SQ_N; k++) begin
				sqg_s[k] <= sqg_s[k-1];
			end
		end
	end

	assign out_valid = vld_q[tci_pkg::DIST_LAT-1];
	assign rng.g = sqg_s[tci_pkg::SQ_N-1];
	assign rng.r1 = sqst_s[0][tci_pkg::SQ_N-1].root;
	assign rng.r2 = sqst_s[1][tci_pkg::SQ_N-1].root;
	assign rng.d = sqst_s[2][tci_pkg::SQ_N-1].root;

endmodule

>>> rtl/tci_solve.sv
// ----------------------------------------------------------------------------
// tci_solve
// Tangent test, chord distance a = N/(2D) and half chord h = sqrt(r1^2 - a^2).
// ----------------------------------------------------------------------------
module tci_solve (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic [tci_pkg::TW-1:0] tol,
	input  logic            in_valid,
	input  tci_pkg::dist_t  rng,
	output logic            out_valid,
	output tci_pkg::sol_t   sol
);

	typedef struct packed {
		tci_pkg::geo_t g;
		logic [tci_pkg::RW-1:0] r1;
		logic [tci_pkg::RW-1:0] d;
		logic [tci_pkg::SW-1:0] r1s;
		logic [tci_pkg::RW-1:0] aq;
		logic neg;
		logic tan;
		logic far;
	} side_t;

	logic [tci_pkg::SOLVE_LAT-1:0] vld_q;

	tci_pkg::geo_t g_s1, g_s2, g_s3, g_s4;
	logic [tci_pkg::RW-1:0] r1_s1, r1_s2, r1_s3, r1_s4;
	logic [tci_pkg::RW-1:0] d_s1, d_s2, d_s3, d_s4;
	logic [tci_pkg::RW:0] s_s1;
	logic [tci_pkg::SW-1:0] r1s_s1, r2s_s1, ds_s1;
	logic [tci_pkg::SW-1:0] r1s_s2, r2s_s2, r1s_s3, r1s_s4;
	logic [tci_pkg::NW-1:0] p2_s1, p2_s2, p2_s3, p2_s4;
	logic signed [tci_pkg::RW+1:0] sd_s2;
	logic [tci_pkg::NW-1:0] pos_s2;
	logic [tci_pkg::RW:0] gap_s3;
	logic signed [tci_pkg::NW:0] nd_s3;
	logic tan_s4, neg_s4;
	logic [tci_pkg::NW-1:0] num_s4;

	tci_pkg::dv_st_t dvst_s [tci_pkg::DV_N];
	logic [tci_pkg::DVW-1:0] dvd_s [tci_pkg::DV_N];
	side_t dvside_s [tci_pkg::DV_N];

	side_t side_s5, side_s6;
	logic [tci_pkg::SW-1:0] aqs_s5, hrad_s6;

	tci_pkg::sq_st_t sqst_s [tci_pkg::SQ_N];
	logic [tci_pkg::SW-1:0] sqrad_s [tci_pkg::SQ_N];
	side_t sqside_s [tci_pkg::SQ_N];

	side_t side_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[tci_pkg::SOLVE_LAT-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g_s1 <= rng.g;
			r1_s1 <= rng.r1;
			d_s1 <= rng.d;
			s_s1 <= {1'b0, rng.r1} + {1'b0, rng.r2};
			r1s_s1 <= rng.r1 * rng.r1;
			r2s_s1 <= rng.r2 * rng.r2;
			ds_s1 <= rng.d * rng.d;
			p2_s1 <= {rng.d, 1'b0} * rng.r1;

			g_s2 <= g_s1;
			r1_s2 <= r1_s1;
			d_s2 <= d_s1;
			r1s_s2 <= r1s_s1;
			r2s_s2 <= r2s_s1;
			p2_s2 <= p2_s1;
			sd_s2 <= $signed({1'b0, s_s1}) - $signed({2'b00, d_s1});
			pos_s2 <= {1'b0, r1s_s1} + {1'b0, ds_s1};

			g_s3 <= g_s2;
			r1_s3 <= r1_s2;
			d_s3 <= d_s2;
			r1s_s3 <= r1s_s2;
			p2_s3 <= p2_s2;
			gap_s3 <= sd_s2[tci_pkg::RW+1] ? (tci_pkg::RW + 1)'(-sd_s2)
				: (tci_pkg::RW + 1)'(sd_s2);
			nd_s3 <= $signed({1'b0, pos_s2}) - $signed({2'b00, r2s_s2});

			g_s4 <= g_s3;
			r1_s4 <= r1_s3;
			d_s4 <= d_s3;
			r1s_s4 <= r1s_s3;
			p2_s4 <= p2_s3;
			tan_s4 <= gap_s3 <= {{(tci_pkg::RW + 1 - tci_pkg::TW){1'b0}}, tol};
			neg_s4 <= nd_s3[tci_pkg::NW];
			num_s4 <= nd_s3[tci_pkg::NW] ? tci_pkg::NW'(-nd_s3) : tci_pkg::NW'(nd_s3);

			dvst_s[0] <= tci_pkg::dv_step({num_s4[tci_pkg::NW-1 -: tci_pkg::DVW],
				{tci_pkg::QW{1'b0}}, num_s4[tci_pkg::QW-1:0]}, {d_s4, 1'b0});
			dvd_s[0] <= {d_s4, 1'b0};
			dvside_s[0].g <= g_s4;
			dvside_s[0].r1 <= r1_s4;
			dvside_s[0].d <= d_s4;
			dvside_s[0].r1s <= r1s_s4;
			dvside_s[0].aq <= '0;
			dvside_s[0].neg <= neg_s4;
			dvside_s[0].tan <= tan_s4;
			dvside_s[0].far <= num_s4 > p2_s4;
			for (int k = 1; k < tci_pkg::DV_N; k++) begin
				dvst_s[k] <= tci_pkg::dv_step(dvst_s[k-1], dvd_s[k-1]);
				dvd_s[k] <= dvd_s[k-1];
				dvside_s[k] <= dvside_s[k-1];
			end

			side_s5.g <= dvside_s[tci_pkg::DV_N-1].g;
			side_s5.r1 <= dvside_s[tci_pkg::DV_N-1].r1;
			side_s5.d <= dvside_s[tci_pkg::DV_N-1].d;
			side_s5.r1s <= dvside_s[tci_pkg::DV_N-1].r1s;
			side_s5.aq <= dvst_s[tci_pkg::DV_N-1].quo;
			side_s5.neg <= dvside_s[tci_pkg::DV_N-1].neg;
			side_s5.tan <= dvside_s[tci_pkg::DV_N-1].tan;
			side_s5.far <= dvside_s[tci_pkg::DV_N-1].far;
			aqs_s5 <= dvst_s[tci_pkg::DV_N-1].quo * dvst_s[tci_pkg::DV_N-1].quo;

			side_s6 <= side_s5;
			hrad_s6 <= side_s5.r1s - aqs_s5;

			sqst_s[0] <= tci_pkg::sq_step('0, hrad_s6[tci_pkg::SW-1 -: 2]);
			sqrad_s[0] <= {hrad_s6[tci_pkg::SW-3:0], 2'b00};
			sqside_s[0] <= side_s6;
			for (int k = 1; k < tci_pkg::SQ_N; k++) begin
				sqst_s[k] <= tci_pkg::sq_step(sqst_s[k-1],
					sqrad_s[k-1][tci_pkg::SW-1 -: 2]);
				sqrad_s[k] <= {sqrad_s[k-1][tci_pkg::SW-3:0], 2'b00};
				sqside_s[k] <= sqside_s[k-1];
			end
		end
	end

	assign out_valid = vld_q[tci_pkg::SOLVE_LAT-1];
	assign side_out = sqside_s[tci_pkg::SQ_N-1];
	assign sol.g = side_out.g;
	assign sol.r1 = side_out.r1;
	assign sol.d = side_out.d;
	assign sol.aq = side_out.aq;
	assign sol.h = sqst_s[tci_pkg::SQ_N-1].root;
	assign sol.neg = side_out.neg;
	assign sol.tan = side_out.tan;
	assign sol.far = side_out.far;

endmodule

>>> rtl/tci_place.sv
// ----------------------------------------------------------------------------
// tci_place
// Scales the anchor vector by a/D and h/D, forms both points, orders them,
// saturates and sets the status.
// ----------------------------------------------------------------------------
module tci_place (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  tci_pkg::sol_t   sol,
	output logic            out_valid,
	output tci_pkg::res_t   res
);

	typedef struct packed {
		tci_pkg::crd_t ax;
		tci_pkg::crd_t ay;
		logic [3:0] sg;
		logic tan;
		logic far;
		logic eyz;
	} side_t;

	function automatic tci_pkg::crd_t sat(logic signed [tci_pkg::XW-1:0] v);
		logic [tci_pkg::XW-tci_pkg::CW:0] hi;
		hi = v[tci_pkg::XW-1:tci_pkg::CW-1];
		if (&hi || ~|hi) begin
			return v[tci_pkg::CW-1:0];
		end
		return v[tci_pkg::XW-1] ? {1'b1, {(tci_pkg::CW - 1){1'b0}}}
			: {1'b0, {(tci_pkg::CW - 1){1'b1}}};
	endfunction

	logic [tci_pkg::PLACE_LAT-1:0] vld_q;

	logic [tci_pkg::RW-1:0] f_s1, h_s1;
	logic fneg_s1;
	logic [tci_pkg::DVW-1:0] dv_s1, dv_s2;
	logic [tci_pkg::DW-1:0] mex_s1, mey_s1;
	logic sgx_s1, sgy_s1;
	side_t side_s1, side_s2;
	logic [tci_pkg::NW-1:0] p_s2 [4];

	tci_pkg::dv_st_t dvst_s [4][tci_pkg::DV_N];
	logic [tci_pkg::DVW-1:0] dvd_s [tci_pkg::DV_N];
	side_t dvside_s [tci_pkg::DV_N];

	side_t side_s3, side_s4, side_s5, side_s6;
	logic signed [tci_pkg::QW:0] q_s3 [4];
	logic signed [tci_pkg::QW+1:0] mx_s4, my_s4;
	logic signed [tci_pkg::QW:0] ox_s4, oy_s4;
	logic signed [tci_pkg::XW-1:0] x1_s5, y1_s5, x2_s5, y2_s5;
	logic signed [tci_pkg::XW-1:0] x1_s6, y1_s6, x2_s6, y2_s6;
	tci_pkg::status_t st_s6;
	tci_pkg::res_t res_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[tci_pkg::PLACE_LAT-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (sol.d == '0) begin
				f_s1 <= '0;
				h_s1 <= '0;
				dv_s1 <= tci_pkg::DVW'(1);
			end else begin
				f_s1 <= sol.tan ? sol.r1 : sol.aq;
				h_s1 <= sol.tan ? '0 : sol.h;
				dv_s1 <= tci_pkg::DVW'(sol.d);
			end
			fneg_s1 <= !sol.tan && sol.neg;
			mex_s1 <= tci_pkg::mag(sol.g.ex);
			mey_s1 <= tci_pkg::mag(sol.g.ey);
			sgx_s1 <= sol.g.ex[tci_pkg::DW-1];
			sgy_s1 <= sol.g.ey[tci_pkg::DW-1];
			side_s1.ax <= sol.g.ax;
			side_s1.ay <= sol.g.ay;
			side_s1.sg <= '0;
			side_s1.tan <= sol.tan;
			side_s1.far <= sol.far;
			side_s1.eyz <= sol.g.ey == '0;

			p_s2[0] <= f_s1 * mex_s1;
			p_s2[1] <= f_s1 * mey_s1;
			p_s2[2] <= h_s1 * mey_s1;
			p_s2[3] <= h_s1 * mex_s1;
			dv_s2 <= dv_s1;
			side_s2.ax <= side_s1.ax;
			side_s2.ay <= side_s1.ay;
			side_s2.tan <= side_s1.tan;
			side_s2.far <= side_s1.far;
			side_s2.eyz <= side_s1.eyz;
			side_s2.sg <= {sgx_s1, !sgy_s1, fneg_s1 ^ sgy_s1, fneg_s1 ^ sgx_s1};

			for (int j = 0; j < 4; j++) begin
				dvst_s[j][0] <= tci_pkg::dv_step({p_s2[j][tci_pkg::NW-1 -: tci_pkg::DVW],
					{tci_pkg::QW{1'b0}}, p_s2[j][tci_pkg::QW-1:0]}, dv_s2);
				for (int k = 1; k < tci_pkg::DV_N; k++) begin
					dvst_s[j][k] <= tci_pkg::dv_step(dvst_s[j][k-1], dvd_s[k-1]);
				end
			end
			dvd_s[0] <= dv_s2;
			dvside_s[0] <= side_s2;
			for (int k = 1; k < tci_pkg::DV_N; k++) begin
				dvd_s[k] <= dvd_s[k-1];
				dvside_s[k] <= dvside_s[k-1];
			end

			for (int j = 0; j < 4; j++) begin
				q_s3[j] <= dvside_s[tci_pkg::DV_N-1].sg[j]
					? -$signed({1'b0, dvst_s[j][tci_pkg::DV_N-1].quo})
					: $signed({1'b0, dvst_s[j][tci_pkg::DV_N-1].quo});
			end
			side_s3 <= dvside_s[tci_pkg::DV_N-1];

			mx_s4 <= (tci_pkg::QW + 2)'(side_s3.ax) + (tci_pkg::QW + 2)'(q_s3[0]);
			my_s4 <= (tci_pkg::QW + 2)'(side_s3.ay) + (tci_pkg::QW + 2)'(q_s3[1]);
			ox_s4 <= q_s3[2];
			oy_s4 <= q_s3[3];
			side_s4 <= side_s3;

			x1_s5 <= tci_pkg::XW'(mx_s4) + tci_pkg::XW'(ox_s4);
			y1_s5 <= tci_pkg::XW'(my_s4) + tci_pkg::XW'(oy_s4);
			x2_s5 <= tci_pkg::XW'(mx_s4) - tci_pkg::XW'(ox_s4);
			y2_s5 <= tci_pkg::XW'(my_s4) - tci_pkg::XW'(oy_s4);
			side_s5 <= side_s4;

			if (x2_s5 > x1_s5) begin
				x1_s6 <= x2_s5;
				y1_s6 <= y2_s5;
				x2_s6 <= x1_s5;
				y2_s6 <= y1_s5;
			end else begin
				x1_s6 <= x1_s5;
				y1_s6 <= y1_s5;
				x2_s6 <= x2_s5;
				y2_s6 <= y2_s5;
			end
			if (side_s5.tan) begin
				st_s6 <= tci_pkg::ST_TAN;
			end else if (side_s5.eyz) begin
				st_s6 <= tci_pkg::ST_SHARE;
			end else if (side_s5.far) begin
				st_s6 <= tci_pkg::ST_FAR;
			end else begin
				st_s6 <= tci_pkg::ST_TWO;
			end
			side_s6 <= side_s5;

			res_s7.st <= st_s6;
			if (st_s6 == tci_pkg::ST_TWO || st_s6 == tci_pkg::ST_TAN) begin
				res_s7.fx <= sat(x1_s6);
				res_s7.fy <= sat(y1_s6);
				res_s7.sx <= sat(x2_s6);
				res_s7.sy <= sat(y2_s6);
			end else begin
				res_s7.fx <= '0;
				res_s7.fy <= '0;
				res_s7.sx <= '0;
				res_s7.sy <= '0;
			end
		end
	end

	assign out_valid = vld_q[tci_pkg::PLACE_LAT-1];
	assign res = res_s7;

endmodule

>>> rtl/two_circle_intersection.sv
// ----------------------------------------------------------------------------
// two_circle_intersection
// Intersection of the circles around two anchors through a tracked point.
// ----------------------------------------------------------------------------
// The block takes one position set per clock while the output is not held
// back and returns one result per set, in order. Every square root and every
// division is unrolled into one register stage per result bit, so all stages
// work on different items at once; a held output transfer freezes the whole
// pipeline and deasserts s_tready. The tolerance register at address 0 resets
// to 0.01 in the coordinate format; the user must write it only while no
// transfer is in flight, as the block itself does not enforce it.
module two_circle_intersection (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// anchor_a_x, anchor_a_y, anchor_b_x, anchor_b_y, probe_x, probe_y
	input  logic [191:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// first_x, first_y, second_x, second_y
	output logic [127:0] m_tdata,
	// solve_status
	output logic [1:0]   m_tuser,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	logic [tci_pkg::TW-1:0] tol_q;
	logic en;
	tci_pkg::pos_t pos;
	tci_pkg::dist_t rng;
	tci_pkg::sol_t sol;
	tci_pkg::res_t res;
	logic dist_vld, sol_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= tci_pkg::TOL_RESET;
		end else if (psel && penable && pwrite && paddr[2] == tci_pkg::REG_TOL) begin
			tol_q <= pwdata[tci_pkg::TW-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == tci_pkg::REG_TOL) ? {{(32 - tci_pkg::TW){1'b0}}, tol_q} : '0;

	assign en = m_tready || !m_tvalid;
	assign s_tready = en;

	assign pos.ax = s_tdata[31:0];
	assign pos.ay = s_tdata[63:32];
	assign pos.bx = s_tdata[95:64];
	assign pos.by = s_tdata[127:96];
	assign pos.px = s_tdata[159:128];
	assign pos.py = s_tdata[191:160];

	tci_dist u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.pos       (pos),
		.out_valid (dist_vld),
		.rng       (rng)
	);

	tci_solve u_solve (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.tol       (tol_q),
		.in_valid  (dist_vld),
		.rng       (rng),
		.out_valid (sol_vld),
		.sol       (sol)
	);

	tci_place u_place (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sol_vld),
		.sol       (sol),
		.out_valid (m_tvalid),
		.res       (res)
	);

	assign m_tdata = {res.sy, res.sx, res.fy, res.fx};
	assign m_tuser = res.st;

	a_tan_same: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == tci_pkg::ST_TAN |-> m_tdata[63:0] == m_tdata[127:64])
		else $error("tangent result with two different points");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == tci_pkg::ST_FAR || m_tuser == tci_pkg::ST_SHARE)
		|-> m_tdata == '0)
		else $error("flag status with nonzero points");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $signed(m_tdata[31:0]) >= $signed(m_tdata[95:64]))
		else $error("first point x below second point x");

endmodule
